@@ hw/rtl/pslb_pkg.sv @@
// shared types and constants for the peak-to-peak sound level bar
// no dependencies; imported by every module of the block
package pslb_pkg;

   // default sample width, handed to the top level parameter
   localparam int SAMPLE_BITS_DEF = 12;

   // fixed field widths
   localparam int WIN_LEN_BITS  = 16;
   localparam int CALIB_BITS    = 8;
   localparam int LEVEL_BITS    = 9;
   localparam int LED_BITS      = 4;
   localparam int CSUM_BITS     = 17;
   localparam int DIVISOR_BITS  = 9;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int THR_BITS      = 10;

   // divider step counter, one quotient bit per step
   localparam int DIV_STEPS     = CSUM_BITS;
   localparam int DIV_STEP_BITS = $clog2(DIV_STEPS + 1);

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_WINDOW_LEN    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_CALIB_WINDOWS = 2'd1;

   // register reset values
   localparam logic [WIN_LEN_BITS-1:0] WIN_LEN_RESET = 16'd2000;
   localparam logic [CALIB_BITS-1:0]   CALIB_RESET   = 8'd20;

   // full scale 3.3 v in centivolts
   localparam logic [LEVEL_BITS-1:0] FULL_SCALE_CV = 9'd330;

   // led thresholds above the baseline, in centivolts
   localparam logic [THR_BITS-1:0] THR_LED1 = 10'd5;
   localparam logic [THR_BITS-1:0] THR_LED2 = 10'd50;
   localparam logic [THR_BITS-1:0] THR_LED3 = 10'd100;
   localparam logic [THR_BITS-1:0] THR_LED4 = 10'd120;
   localparam logic [THR_BITS-1:0] THR_TOP  = 10'd280;

   // led patterns
   localparam logic [LED_BITS-1:0] LED_NONE  = 4'b0000;
   localparam logic [LED_BITS-1:0] LED_ONE   = 4'b0001;
   localparam logic [LED_BITS-1:0] LED_TWO   = 4'b0011;
   localparam logic [LED_BITS-1:0] LED_THREE = 4'b0111;
   localparam logic [LED_BITS-1:0] LED_FOUR  = 4'b1111;

   // controller to datapath commands
   typedef struct packed {
      logic accept;     // take the sample into the window
      logic mul;        // form peak-to-peak times full scale, reopen window
      logic lvl;        // scale product down to centivolts
      logic post;       // calibration sum or led update
      logic div_start;  // launch baseline division
      logic load_out;   // load result word into the output register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic end_win;    // incoming sample closes the window
      logic cal_done;   // this window completes calibration
      logic div_done;   // baseline quotient ready
   } status_type;

endpackage

@@ hw/rtl/pslb_div.sv @@
// restoring divider for the baseline mean, one quotient bit per cycle
// depends on pslb_pkg
module pslb_div
   import pslb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [CSUM_BITS-1:0]    dividend,
   input  logic [DIVISOR_BITS-1:0] divisor,
   output logic                    done,
   output logic [CSUM_BITS-1:0]    quotient
);

   logic                     active_ff, active_in;
   logic                     done_ff, done_in;
   logic [DIV_STEP_BITS-1:0] step_ff, step_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  dsr_ff, dsr_in;
   logic [CSUM_BITS-1:0]     dvd_ff, dvd_in;
   logic [DIVISOR_BITS:0]    trial;
   logic                     qbit;

   assign trial = {rem_ff, dvd_ff[CSUM_BITS-1]};
   assign qbit  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      dvd_in    = dvd_ff;
      if (start) begin
         active_in = 1'b1;
         step_in   = '0;
         rem_in    = '0;
         dsr_in    = divisor;
         dvd_in    = dividend;
      end else if (active_ff) begin
         rem_in  = qbit ? DIVISOR_BITS'(trial - {1'b0, dsr_ff}) : trial[DIVISOR_BITS-1:0];
         dvd_in  = {dvd_ff[CSUM_BITS-2:0], qbit};
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_STEP_BITS'(DIV_STEPS - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         step_ff   <= step_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      dvd_ff <= dvd_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

@@ hw/rtl/pslb_dp.sv @@
// datapath: config registers, window min/max, level scaling,
// calibration sum, led bar and output register; depends on pslb_pkg, pslb_div
module pslb_dp
   import pslb_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic [SAMPLE_BITS-1:0]   sample,
   input  cmd_type                  cmd,
   output status_type               status,
   output logic [LEVEL_BITS-1:0]    level_cv,
   output logic [LED_BITS-1:0]      led_bar,
   output logic [LEVEL_BITS-1:0]    baseline_cv,
   output logic                     calibrating
);

   localparam int PROD_BITS = SAMPLE_BITS + LEVEL_BITS;

   logic [WIN_LEN_BITS-1:0] window_len_ff;
   logic [CALIB_BITS-1:0]   calib_windows_ff;

   logic [SAMPLE_BITS-1:0]  win_max_ff, win_min_ff;
   logic [WIN_LEN_BITS-1:0] sample_count_ff;
   logic [PROD_BITS-1:0]    product_ff;
   logic [LEVEL_BITS-1:0]   level_ff;
   logic [CALIB_BITS-1:0]   window_count_ff;
   logic [CSUM_BITS-1:0]    calib_sum_ff;
   logic [LEVEL_BITS-1:0]   baseline_ff;
   logic [LED_BITS-1:0]     led_ff;
   logic                    in_cal_ff;
   logic                    was_cal_ff;

   logic [LEVEL_BITS-1:0]   out_level_ff, out_base_ff;
   logic [LED_BITS-1:0]     out_led_ff;
   logic                    out_cal_ff;

   logic [WIN_LEN_BITS-1:0] count_next, len_eff;
   logic [CALIB_BITS-1:0]   wcount_next, cal_len;
   logic [SAMPLE_BITS-1:0]  diff;
   logic [DIVISOR_BITS-1:0] div_n;
   logic [CSUM_BITS-1:0]    quotient;
   logic                    div_done;

   function automatic logic [LED_BITS-1:0] bar_for(
      input logic [LEVEL_BITS-1:0] lvl,
      input logic [LEVEL_BITS-1:0] base,
      input logic [LED_BITS-1:0]   pat
   );
      logic [THR_BITS-1:0] l, b;
      logic [LED_BITS-1:0] r;
      l = THR_BITS'(lvl);
      b = THR_BITS'(base);
      r = pat;
      if (l < b + THR_LED1)
         r = LED_NONE;
      else if (l > b + THR_LED1 && l < b + THR_LED2)
         r = LED_ONE;
      else if (l > b + THR_LED2 && l < b + THR_LED3)
         r = LED_TWO;
      else if (l > b + THR_LED3 && l < b + THR_LED4)
         r = LED_THREE;
      else if (l > b + THR_LED4 && l < b + THR_TOP)
         r = LED_FOUR;
      return r;
   endfunction

   // window end: count wraps or reaches the length, zero length acts as one
   assign count_next = sample_count_ff + 1'b1;
   assign len_eff    = (window_len_ff == '0) ? WIN_LEN_BITS'(1) : window_len_ff;
   assign status.end_win = (count_next == '0) || (count_next >= len_eff);

   assign wcount_next = window_count_ff + 1'b1;
   assign cal_len     = (calib_windows_ff == '0) ? CALIB_BITS'(1) : calib_windows_ff;
   assign status.cal_done = in_cal_ff && ((wcount_next == '0) || (wcount_next >= cal_len));
   assign status.div_done = div_done;

   assign diff  = (win_max_ff >= win_min_ff) ? (win_max_ff - win_min_ff) : '0;
   // zero count stands for 256 windows
   assign div_n = (window_count_ff == '0) ? DIVISOR_BITS'(256)
                                          : DIVISOR_BITS'(window_count_ff);

   pslb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (calib_sum_ff),
      .divisor  (div_n),
      .done     (div_done),
      .quotient (quotient)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff    <= WIN_LEN_RESET;
         calib_windows_ff <= CALIB_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_WINDOW_LEN:    window_len_ff    <= csr_wdata[WIN_LEN_BITS-1:0];
            REG_CALIB_WINDOWS: calib_windows_ff <= csr_wdata[CALIB_BITS-1:0];
            default: ;
         endcase
      end
   end

   // window tracking and measurement state
   always_ff @(posedge clock) begin
      if (reset) begin
         win_max_ff      <= '0;
         win_min_ff      <= '1;
         sample_count_ff <= '0;
         window_count_ff <= '0;
         calib_sum_ff    <= '0;
         baseline_ff     <= '0;
         led_ff          <= LED_NONE;
         in_cal_ff       <= 1'b1;
         was_cal_ff      <= 1'b0;
      end else begin
         if (cmd.accept) begin
            if (sample > win_max_ff)
               win_max_ff <= sample;
            if (sample < win_min_ff)
               win_min_ff <= sample;
            sample_count_ff <= status.end_win ? '0 : count_next;
         end
         if (cmd.mul) begin
            win_max_ff <= '0;
            win_min_ff <= '1;
         end
         if (cmd.post) begin
            was_cal_ff <= in_cal_ff;
            if (in_cal_ff) begin
               calib_sum_ff    <= calib_sum_ff + CSUM_BITS'(level_ff);
               window_count_ff <= wcount_next;
               if (status.cal_done)
                  in_cal_ff <= 1'b0;
            end else begin
               led_ff <= bar_for(level_ff, baseline_ff, led_ff);
            end
         end
         if (div_done)
            baseline_ff <= quotient[LEVEL_BITS-1:0];
      end
   end

   // arithmetic pipeline and output register, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.mul)
         product_ff <= PROD_BITS'(diff) * PROD_BITS'(FULL_SCALE_CV);
      if (cmd.lvl)
         level_ff <= product_ff[PROD_BITS-1:SAMPLE_BITS];
      if (cmd.load_out) begin
         out_level_ff <= level_ff;
         out_led_ff   <= led_ff;
         out_base_ff  <= baseline_ff;
         out_cal_ff   <= was_cal_ff;
      end
   end

   assign level_cv    = out_level_ff;
   assign led_bar     = out_led_ff;
   assign baseline_cv = out_base_ff;
   assign calibrating = out_cal_ff;

endmodule

@@ hw/rtl/pslb_ctrl.sv @@
// controller: sequences one sample, the window-end steps and the
// baseline division, and owns the output valid; depends on pslb_pkg
module pslb_ctrl
   import pslb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL    = 3'd1;
   localparam logic [2:0] ST_LVL    = 3'd2;
   localparam logic [2:0] ST_POST   = 3'd3;
   localparam logic [2:0] ST_DSTART = 3'd4;
   localparam logic [2:0] ST_DWAIT  = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.accept    = (state_ff == ST_IDLE) && req_valid;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.end_win)
               state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_LVL;
         end
         ST_LVL: begin
            cmd.lvl  = 1'b1;
            state_in = ST_POST;
         end
         ST_POST: begin
            cmd.post = 1'b1;
            state_in = status.cal_done ? ST_DSTART : ST_OUT;
         end
         ST_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (status.div_done)
               state_in = ST_OUT;
         end
         ST_OUT: begin
            cmd.load_out = out_free;
            if (out_free)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_out)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/peak_to_peak_sound_level_bar_unit.sv @@
// top level of the peak-to-peak sound level bar
// depends on pslb_pkg, pslb_ctrl, pslb_dp (and pslb_div below it)
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+-------------------------------------
//   req     | in        | req_valid / req_stall  | req_sample
//   rsp     | out       | rsp_valid / rsp_stall  | level_cv, led_bar, baseline_cv, calib
//   csr     | in        | csr_write_en           | csr_index, csr_wdata
//
// a sample that does not close its window leaves the controller idle; the next word may follow
// at once. a window-closing sample steps through accept, multiply by full scale,
// scale to centivolts, calibration/led update, output load. the window that ends
// calibration adds a start and wait for the bit-serial baseline divider (one bit a cycle).
// req_stall is high through those steps and longer while rsp_stall holds the last word
// reset is synchronous and restores register defaults and calibration mode.
module peak_to_peak_sound_level_bar_unit
   import pslb_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // sample input
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [SAMPLE_BITS-1:0]   req_sample,
   // result output
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [LEVEL_BITS-1:0]    rsp_level_cv,
   output logic [LED_BITS-1:0]      rsp_led_bar,
   output logic [LEVEL_BITS-1:0]    rsp_baseline_cv,
   output logic                     rsp_calibrating,
   // configuration writes
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // sequencing of samples, window-end steps and division
   pslb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // all arithmetic and state of the meter
   pslb_dp #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .sample       (req_sample),
      .cmd          (cmd),
      .status       (status),
      .level_cv     (rsp_level_cv),
      .led_bar      (rsp_led_bar),
      .baseline_cv  (rsp_baseline_cv),
      .calibrating  (rsp_calibrating)
   );

`ifndef SYNTH
   // led word is always a thermometer code
   a_led_thermo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_led_bar == LED_NONE || rsp_led_bar == LED_ONE ||
                     rsp_led_bar == LED_TWO || rsp_led_bar == LED_THREE ||
                     rsp_led_bar == LED_FOUR))
      else $error("led bar not a thermometer code");

   // leds stay dark while the baseline is being gathered
   a_cal_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_calibrating) |-> (rsp_led_bar == LED_NONE))
      else $error("leds lit during calibration");

   // scaled level never reaches full scale
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_level_cv < FULL_SCALE_CV))
      else $error("level beyond full scale");
`endif

endmodule

@@ verif/pslb_level_checker.sv @@
`timescale 1ns / 1ps
// result checker for the peak-to-peak sound level bar: tracks window state, predicts words
// depends on pslb_pkg; instantiated by tb beside the block under test
module pslb_level_checker
   import pslb_pkg::*;
#(
   parameter int SW = SAMPLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [SW-1:0]            req_sample,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [LEVEL_BITS-1:0]    rsp_level_cv,
   input  logic [LED_BITS-1:0]      rsp_led_bar,
   input  logic [LEVEL_BITS-1:0]    rsp_baseline_cv,
   input  logic                     rsp_calibrating,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int                       fail_count,
   output int                       pending_words
);

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level_cv;
      logic [LED_BITS-1:0]   led_bar;
      logic [LEVEL_BITS-1:0] baseline_cv;
      logic                  calibrating;
   } level_word_type;

   logic [WIN_LEN_BITS-1:0] win_len_r;
   logic [CALIB_BITS-1:0]   calib_len_r;
   logic [SW-1:0]           peak_hi;
   logic [SW-1:0]           peak_lo;
   logic [WIN_LEN_BITS-1:0] samples_in_win;
   logic [CALIB_BITS-1:0]   windows_seen;
   logic [CSUM_BITS-1:0]    level_sum;
   logic [LEVEL_BITS-1:0]   baseline_r;
   logic [LED_BITS-1:0]     led_r;
   logic                    calibrating_r;
   level_word_type          levels_due[$];

   // thermometer bar against the baseline; boundaries and the top band keep the old bar
   function automatic logic [LED_BITS-1:0] led_for_level(input int unsigned lvl);
      int unsigned b;
      b = int'(baseline_r);
      if (lvl < b + THR_LED1)
         return LED_NONE;
      else if (lvl > b + THR_LED1 && lvl < b + THR_LED2)
         return LED_ONE;
      else if (lvl > b + THR_LED2 && lvl < b + THR_LED3)
         return LED_TWO;
      else if (lvl > b + THR_LED3 && lvl < b + THR_LED4)
         return LED_THREE;
      else if (lvl > b + THR_LED4 && lvl < b + THR_TOP)
         return LED_FOUR;
      else
         return led_r;
   endfunction

   task automatic measure_sample(input logic [SW-1:0] s, output bit closed,
                                 output level_word_type w);
      int unsigned span_cv;
      int unsigned win_target;
      int unsigned cal_target;
      int unsigned divisor;
      closed = 1'b0;
      w = '0;
      if (s > peak_hi) peak_hi = s;
      if (s < peak_lo) peak_lo = s;
      samples_in_win = samples_in_win + 1'b1;
      win_target = (win_len_r == '0) ? 1 : win_len_r;
      cal_target = (calib_len_r == '0) ? 1 : calib_len_r;
      if (samples_in_win == '0 || samples_in_win >= win_target) begin
         closed = 1'b1;
         span_cv = (peak_hi >= peak_lo)
                 ? ((int'(peak_hi - peak_lo) * int'(FULL_SCALE_CV)) >> SW) : 0;
         w.level_cv = span_cv[LEVEL_BITS-1:0];
         peak_hi = '0;
         peak_lo = '1;
         samples_in_win = '0;
         w.calibrating = calibrating_r;
         if (calibrating_r) begin
            level_sum = level_sum + w.level_cv;
            windows_seen = windows_seen + 1'b1;
            if (windows_seen == '0 || windows_seen >= cal_target) begin
               divisor = (windows_seen == '0) ? 256 : windows_seen;
               baseline_r = LEVEL_BITS'(level_sum / divisor);
               calibrating_r = 1'b0;
            end
         end else begin
            led_r = led_for_level(w.level_cv);
         end
         w.led_bar = led_r;
         w.baseline_cv = baseline_r;
      end
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      bit             closed;
      level_word_type word_now;
      level_word_type oldest;
      if (reset) begin
         win_len_r = WIN_LEN_RESET;
         calib_len_r = CALIB_RESET;
         peak_hi = '0;
         peak_lo = '1;
         samples_in_win = '0;
         windows_seen = '0;
         level_sum = '0;
         baseline_r = '0;
         led_r = LED_NONE;
         calibrating_r = 1'b1;
         levels_due.delete();
         fail_count = 0;
      end else begin
         // retire first: a word leaving now belongs to an older sample
         if (rsp_valid && !rsp_stall) begin
            if (levels_due.size() == 0) begin
               $display("%0t: level word with nothing expected, actual level %0d led %b",
                        $time, rsp_level_cv, rsp_led_bar);
               fail_count++;
            end else begin
               oldest = levels_due.pop_front();
               check_field("level_cv", oldest.level_cv, rsp_level_cv);
               check_field("led_bar", oldest.led_bar, rsp_led_bar);
               check_field("baseline_cv", oldest.baseline_cv, rsp_baseline_cv);
               check_field("calibrating", oldest.calibrating, rsp_calibrating);
            end
         end
         if (req_valid && !req_stall) begin
            measure_sample(req_sample, closed, word_now);
            if (closed) levels_due.push_back(word_now);
         end
         if (csr_write_en) begin
            if (csr_index == REG_WINDOW_LEN)
               win_len_r = csr_wdata[WIN_LEN_BITS-1:0];
            else if (csr_index == REG_CALIB_WINDOWS)
               calib_len_r = csr_wdata[CALIB_BITS-1:0];
         end
      end
      pending_words <= levels_due.size();
   end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// bench top for peak_to_peak_sound_level_bar_unit: clock, reset, sample and stall stimulus
// depends on pslb_pkg, the block and pslb_level_checker, which does all the comparing
module tb;
   import pslb_pkg::*;

   localparam int SW               = SAMPLE_BITS_DEF;
   localparam int SAMPLE_TOP       = (1 << SW) - 1;
   localparam int ITEMS_PER_REGIME = 510;
   // margin for a window close and the baseline divide to finish
   localparam int DRAIN_CYCLES     = 40;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int TIMEOUT_NS       = 5_000_000;
   // baseline that the directed calibration windows are built to give
   localparam int BASELINE_CV      = 14;
   // indexes past the two registers, which the block must ignore
   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE_HI = 2'd3;

   // where a directed two-sample window sits on the adc range
   typedef enum int {AT_BOTTOM, AT_TOP, ANYWHERE} placing_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [SW-1:0]            req_sample = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [LEVEL_BITS-1:0]    rsp_level_cv;
   logic [LED_BITS-1:0]      rsp_led_bar;
   logic [LEVEL_BITS-1:0]    rsp_baseline_cv;
   logic                     rsp_calibrating;
   logic                     csr_write_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   int fail_count;
   int pending_words;
   // idle odds in percent, set per regime by the stimulus
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // long receiver hold-off: asked by the stimulus, carried out by the receiver
   bit long_hold_go = 1'b0;
   bit long_hold_done = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   peak_to_peak_sound_level_bar_unit #(
      .SAMPLE_BITS(SW)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_level_cv   (rsp_level_cv),
      .rsp_led_bar    (rsp_led_bar),
      .rsp_baseline_cv(rsp_baseline_cv),
      .rsp_calibrating(rsp_calibrating),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   pslb_level_checker #(
      .SW(SW)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_level_cv   (rsp_level_cv),
      .rsp_led_bar    (rsp_led_bar),
      .rsp_baseline_cv(rsp_baseline_cv),
      .rsp_calibrating(rsp_calibrating),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending_words  (pending_words)
   );

   // one register write per edge; the caller drops the enable after the last one
   task automatic csr_put(input logic [CSR_IDX_BITS-1:0] idx,
                          input logic [CSR_DATA_BITS-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
   endtask

   // both registers, then a write to an unused index with random data
   task automatic apply_settings(input logic [CSR_DATA_BITS-1:0] win_len,
                                 input logic [CSR_DATA_BITS-1:0] calib_len);
      csr_put(REG_WINDOW_LEN, win_len);
      csr_put(REG_CALIB_WINDOWS, calib_len);
      csr_put($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
              CSR_DATA_BITS'($urandom_range(0, 16'hFFFF)));
      csr_write_en <= 1'b0;
   endtask

   // offer one sample word, with random gaps ahead of it, and hold it until taken
   task automatic offer_sample(input logic [SW-1:0] s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
   endtask

   // a two-sample window whose spread scales to exactly lvl centivolts
   task automatic offer_level_window(input int unsigned lvl, input placing_type placing);
      int unsigned   span;
      logic [SW-1:0] lo;
      span = ((lvl << SW) + FULL_SCALE_CV - 1) / FULL_SCALE_CV;
      case (placing)
         AT_BOTTOM: lo = '0;
         AT_TOP:    lo = SW'(SAMPLE_TOP - span);
         default:   lo = SW'($urandom_range(0, SAMPLE_TOP - span));
      endcase
      if ($urandom_range(0, 1)) begin
         offer_sample(lo);
         offer_sample(SW'(lo + span));
      end else begin
         offer_sample(SW'(lo + span));
         offer_sample(lo);
      end
   endtask

   // stop offering, wait for every expected word, then let the block go quiet
   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // receiver: random stall per cycle, plus one long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_go && !long_hold_done) begin
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("peak_to_peak_sound_level_bar_unit verification failed");
      $finish;
   end

   initial begin
      logic [WIN_LEN_BITS-1:0] wlen;
      int phase_items;
      int regime_items;
      int amp;
      int base;
      bit first_phase;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part runs under the first regime's idling
      send_idle_pct = 20;
      recv_idle_pct = 85;

      // calibration: two-sample windows at 10 and 13 cv, six windows asked for
      apply_settings(16'd2, 16'd6);
      offer_level_window(10, AT_BOTTOM);
      offer_level_window(13, ANYWHERE);
      drain;
      // zero calibration count acts as one, so the next window forms the baseline
      apply_settings(16'd2, 16'd0);
      // (10 + 13 + 20) / 3 truncates to the baseline of 14
      offer_level_window(20, ANYWHERE);
      drain;

      // bar stepping up, each band followed by a level right on its lower edge
      apply_settings(16'd2, 16'hFFFF);
      offer_level_window(BASELINE_CV + 30, ANYWHERE);
      offer_level_window(BASELINE_CV + THR_LED1, ANYWHERE);
      offer_level_window(BASELINE_CV + 75, ANYWHERE);
      offer_level_window(BASELINE_CV + THR_LED2, ANYWHERE);
      offer_level_window(BASELINE_CV + 110, ANYWHERE);
      offer_level_window(BASELINE_CV + THR_LED3, ANYWHERE);
      offer_level_window(BASELINE_CV + 200, AT_TOP);
      offer_level_window(BASELINE_CV + THR_LED4, ANYWHERE);
      // top threshold itself leaves the bar alone
      offer_level_window(BASELINE_CV + THR_TOP, ANYWHERE);
      drain;

      // zero window length acts as one: a lone sample, zero level, bar goes dark
      apply_settings(16'd0, CSR_DATA_BITS'($urandom_range(0, 16'hFFFF)));
      offer_sample(SW'($urandom_range(0, SAMPLE_TOP)));
      drain;

      // longest window, part filled, then shortened to the count already in it
      apply_settings(16'hFFFF, CSR_DATA_BITS'($urandom_range(0, 16'hFFFF)));
      offer_sample(SW'($urandom_range(0, SAMPLE_TOP)));
      offer_sample(SW'($urandom_range(0, SAMPLE_TOP)));
      drain;
      apply_settings(16'd2, CSR_DATA_BITS'($urandom_range(0, 16'hFFFF)));
      offer_sample(SW'($urandom_range(0, SAMPLE_TOP)));

      // random phases: sender idles lightly, then heavily, then neither side idles
      for (int r = 0; r < 3; r++) begin
         case (r)
            0: begin
               send_idle_pct = 20;
               recv_idle_pct = 85;
            end
            1: begin
               send_idle_pct = 85;
               recv_idle_pct = 20;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         regime_items = 0;
         first_phase = 1'b1;
         while (regime_items < ITEMS_PER_REGIME) begin
            drain;
            // mostly short windows so that words come often; now and then long ones
            case ($urandom_range(0, 9))
               0:             wlen = '0;
               1:             wlen = 16'd1;
               2, 3, 4, 5, 6: wlen = WIN_LEN_BITS'($urandom_range(2, 8));
               7:             wlen = WIN_LEN_BITS'($urandom_range(9, 40));
               8:             wlen = WIN_LEN_BITS'($urandom_range(41, 400));
               default:       wlen = 16'hFFFF;
            endcase
            // every sample closes a window while the receiver holds off
            if (r == 2 && first_phase) wlen = 16'd1;
            apply_settings(wlen, CSR_DATA_BITS'($urandom_range(0, 16'hFFFF)));
            if (r == 2 && first_phase) long_hold_go = 1'b1;

            // spread of the samples sets how high the levels climb
            case ($urandom_range(0, 3))
               0:       amp = SAMPLE_TOP;
               1:       amp = $urandom_range(0, 400);
               default: amp = $urandom_range(0, SAMPLE_TOP);
            endcase
            base = $urandom_range(0, SAMPLE_TOP - amp);
            phase_items = (wlen > 400) ? $urandom_range(5, 60) : $urandom_range(10, 80);
            repeat (phase_items) offer_sample(SW'(base + $urandom_range(0, amp)));
            regime_items += phase_items;
            first_phase = 1'b0;
         end
      end

      drain;
      if (fail_count == 0 && pending_words == 0)
         $display("peak_to_peak_sound_level_bar_unit verification clean");
      else
         $display("peak_to_peak_sound_level_bar_unit verification failed");
      $finish;
   end

endmodule
